// File: hdl/ir_pd_pkg.sv
// ----------------------------------------------------------------------------
// ir_pd_pkg
// Shared types, constants and helper functions of the IR pulse-distance
// key decoder: register map, timing windows and the key code table.
// ----------------------------------------------------------------------------
package ir_pd_pkg;

    localparam int APB_AW       = 5;
    localparam int APB_DW       = 32;
    localparam int WIN_W        = 16;
    localparam int TIME_W       = 32;
    localparam int POS_W        = 5;
    localparam int KEY_W        = 4;
    localparam int NUM_CODES    = 10;

    localparam logic [POS_W-1:0] KEY_BYTE_FIRST = 5'd16;
    localparam logic [POS_W-1:0] KEY_BYTE_LAST  = 5'd23;
    localparam logic [POS_W-1:0] LAST_BIT_POS   = 5'd31;

    typedef enum logic [2:0] {
        REG_LEADER_MIN = 3'd0,
        REG_LEADER_MAX = 3'd1,
        REG_REPEAT_MIN = 3'd2,
        REG_REPEAT_MAX = 3'd3,
        REG_ZERO_MIN   = 3'd4,
        REG_ZERO_MAX   = 3'd5,
        REG_ONE_MIN    = 3'd6,
        REG_ONE_MAX    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [WIN_W-1:0] leader_min;
        logic [WIN_W-1:0] leader_max;
        logic [WIN_W-1:0] repeat_min;
        logic [WIN_W-1:0] repeat_max;
        logic [WIN_W-1:0] zero_min;
        logic [WIN_W-1:0] zero_max;
        logic [WIN_W-1:0] one_min;
        logic [WIN_W-1:0] one_max;
    } t_windows;

    localparam logic [7:0] CODE_TABLE [NUM_CODES] = '{
        8'h68, 8'h30, 8'h18, 8'h7A, 8'h10, 8'h38, 8'h5A, 8'h42, 8'h4A, 8'h52
    };

    // Open interval test, lo < v < hi.
    function automatic logic in_window(input logic [TIME_W-1:0] v,
                                       input logic [WIN_W-1:0]  lo,
                                       input logic [WIN_W-1:0]  hi);
        logic [TIME_W-1:0] lo_x;
        logic [TIME_W-1:0] hi_x;
        lo_x = {{(TIME_W-WIN_W){1'b0}}, lo};
        hi_x = {{(TIME_W-WIN_W){1'b0}}, hi};
        return (v > lo_x) && (v < hi_x);
    endfunction

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] digit;
    } t_lookup;

    function automatic t_lookup code_lookup(input logic [7:0] b);
        t_lookup res;
        res = '0;
        for (int k = NUM_CODES - 1; k >= 0; k--) begin
            if (b == CODE_TABLE[k]) begin
                res.hit   = 1'b1;
                res.digit = KEY_W'(k);
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/ir_pulse_distance_key_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_key_decoder
// Decodes NEC-style IR frames from falling-edge timestamps into key digits.
// ----------------------------------------------------------------------------
// Path: the edge lands in the input register, then is classified and decoded
//   into the result register.
// Throughput: one edge per cycle; the decode stage stalls only while the
//   result register holds a transaction not yet taken.
// Reset: synchronous active low; clears frame state, last key and valid
//   flags, and loads the default window bounds.
module ir_pulse_distance_key_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ir_pd_pkg::APB_AW-1:0]      paddr,
    input  logic [ir_pd_pkg::APB_DW-1:0]      pwdata,
    output logic [ir_pd_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ir_pd_pkg::TIME_W-1:0]      i_edge_time,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ir_pd_pkg::KEY_W-1:0]       o_key_digit,
    output logic                              o_is_repeat
);
    import ir_pd_pkg::*;

    t_windows win;

    ir_pd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_win   (win)
    );

    // Input register
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic              s2_fire;

    // Decoder state
    logic              r_have_prev,  n_have_prev;
    logic [TIME_W-1:0] r_prev_time,  n_prev_time;
    logic              r_frame_open, n_frame_open;
    logic [POS_W-1:0]  r_bit_pos,    n_bit_pos;
    logic [7:0]        r_key_byte,   n_key_byte;
    logic [KEY_W-1:0]  r_last_key,   n_last_key;
    logic              r_key_known,  n_key_known;

    // Result register
    logic              r_out_valid;
    logic [KEY_W-1:0]  r_key_digit;
    logic              r_is_repeat;

    logic              res_vld;
    logic [KEY_W-1:0]  res_digit;
    logic              res_rep;
    logic [TIME_W-1:0] interval;
    logic [POS_W-1:0]  byte_sel;
    logic [7:0]        bits_upd;
    t_lookup           lk;

    assign s2_fire    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s2_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_time <= i_edge_time;
        end
    end

    assign interval = r_in_time - r_prev_time;
    assign byte_sel = KEY_BYTE_LAST - r_bit_pos;

    // Bit update of the key byte; one window wins over zero when both match.
    always_comb begin
        bits_upd = r_key_byte;
        if (r_bit_pos inside {[KEY_BYTE_FIRST:KEY_BYTE_LAST]}) begin
            if (in_window(interval, win.zero_min, win.zero_max)) begin
                bits_upd[byte_sel[2:0]] = 1'b0;
            end
            if (in_window(interval, win.one_min, win.one_max)) begin
                bits_upd[byte_sel[2:0]] = 1'b1;
            end
        end
    end

    assign lk = code_lookup(bits_upd);

    always_comb begin
        n_have_prev  = r_have_prev;
        n_prev_time  = r_prev_time;
        n_frame_open = r_frame_open;
        n_bit_pos    = r_bit_pos;
        n_key_byte   = r_key_byte;
        n_last_key   = r_last_key;
        n_key_known  = r_key_known;
        res_vld      = 1'b0;
        res_digit    = r_last_key;
        res_rep      = 1'b0;
        if (s2_fire) begin
            n_have_prev = 1'b1;
            n_prev_time = r_in_time;
            if (r_have_prev) begin
                if (in_window(interval, win.leader_min, win.leader_max)) begin
                    n_frame_open = 1'b1;
                    n_bit_pos    = '0;
                end else if (in_window(interval, win.repeat_min, win.repeat_max)) begin
                    n_frame_open = 1'b0;
                    n_bit_pos    = '0;
                    res_vld      = r_key_known;
                    res_digit    = r_last_key;
                    res_rep      = 1'b1;
                end else if (r_frame_open) begin
                    n_key_byte = bits_upd;
                    if (r_bit_pos == LAST_BIT_POS) begin
                        // Frame complete: close and look the key byte up.
                        n_frame_open = 1'b0;
                        n_bit_pos    = '0;
                        if (lk.hit) begin
                            n_last_key  = lk.digit;
                            n_key_known = 1'b1;
                            res_vld     = 1'b1;
                            res_digit   = lk.digit;
                            res_rep     = 1'b0;
                        end
                    end else begin
                        n_bit_pos = r_bit_pos + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_prev_time  <= '0;
            r_frame_open <= 1'b0;
            r_bit_pos    <= '0;
            r_key_byte   <= '0;
            r_last_key   <= '0;
            r_key_known  <= 1'b0;
        end else begin
            r_have_prev  <= n_have_prev;
            r_prev_time  <= n_prev_time;
            r_frame_open <= n_frame_open;
            r_bit_pos    <= n_bit_pos;
            r_key_byte   <= n_key_byte;
            r_last_key   <= n_last_key;
            r_key_known  <= n_key_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && res_vld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && res_vld) begin
            r_key_digit <= res_digit;
            r_is_repeat <= res_rep;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_digit = r_key_digit;
    assign o_is_repeat = r_is_repeat;

    // Assertions
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_digit <= KEY_W'(NUM_CODES - 1)))
        else $error("key digit out of range");

    a_repeat_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_repeat) |-> r_key_known)
        else $error("repeat result without a known key");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_pos != '0) |-> r_frame_open)
        else $error("bit position advanced outside a frame");

    a_prev_before_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && !r_have_prev) |=> (r_have_prev && !$rose(r_out_valid)))
        else $error("first edge produced a result");

endmodule

// File: hdl/ir_pd_regs.sv
// ----------------------------------------------------------------------------
// ir_pd_regs
// APB register file holding the eight timing window bounds.
// ----------------------------------------------------------------------------
module ir_pd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ir_pd_pkg::APB_AW-1:0]  paddr,
    input  logic [ir_pd_pkg::APB_DW-1:0]  pwdata,
    output logic [ir_pd_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output ir_pd_pkg::t_windows           o_win
);
    import ir_pd_pkg::*;

    t_windows         r_win;
    t_reg_idx         reg_idx;
    logic             wr_en;
    logic [WIN_W-1:0] wdata;
    logic [WIN_W-1:0] rdata;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign wdata   = pwdata[WIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.leader_min <= 16'd13000;
            r_win.leader_max <= 16'd14000;
            r_win.repeat_min <= 16'd11000;
            r_win.repeat_max <= 16'd12000;
            r_win.zero_min   <= 16'd1000;
            r_win.zero_max   <= 16'd1500;
            r_win.one_min    <= 16'd2000;
            r_win.one_max    <= 16'd2500;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LEADER_MIN: r_win.leader_min <= wdata;
                REG_LEADER_MAX: r_win.leader_max <= wdata;
                REG_REPEAT_MIN: r_win.repeat_min <= wdata;
                REG_REPEAT_MAX: r_win.repeat_max <= wdata;
                REG_ZERO_MIN:   r_win.zero_min   <= wdata;
                REG_ZERO_MAX:   r_win.zero_max   <= wdata;
                REG_ONE_MIN:    r_win.one_min    <= wdata;
                REG_ONE_MAX:    r_win.one_max    <= wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEADER_MIN: rdata = r_win.leader_min;
            REG_LEADER_MAX: rdata = r_win.leader_max;
            REG_REPEAT_MIN: rdata = r_win.repeat_min;
            REG_REPEAT_MAX: rdata = r_win.repeat_max;
            REG_ZERO_MIN:   rdata = r_win.zero_min;
            REG_ZERO_MAX:   rdata = r_win.zero_max;
            REG_ONE_MIN:    rdata = r_win.one_min;
            REG_ONE_MAX:    rdata = r_win.one_max;
            default:        rdata = '0;
        endcase
    end

    assign prdata = {{(APB_DW-WIN_W){1'b0}}, rdata};
    assign o_win  = r_win;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR pulse-distance key decoder. It walks a
// short table of edges and frames, then runs random frames, repeat codes
// and noise under several window settings. It keeps its own model of the
// decoder and compares every decoded key transaction in order with it, or with the table's result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ir_pd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int EDGES_PER_PHASE = 65;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] digit;
        logic             rep;
    } t_key_result;

    typedef enum logic [1:0] {ROW_AT, ROW_GAP, ROW_FRAME, ROW_CFG} t_row_kind;
    typedef enum logic [2:0] {GAP_LEADER, GAP_REPEAT, GAP_ZERO, GAP_ONE, GAP_NONE} t_gap_kind;
    typedef enum logic [2:0] {
        WIN_DEFAULT, WIN_OVERLAP, WIN_SCALED, WIN_EXTREME, WIN_DEAD, WIN_NOISE
    } t_window_set;

    // arg holds an absolute time, a gap kind, a key byte or {register, value}
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] arg;
        logic [31:0] holes;
        logic        typed;
        t_key_result res;
    } t_row;

    localparam t_key_result NO_KEY = '0;
    localparam logic [7:0] KEY_CODES [NUM_CODES] = '{
        8'h68, 8'h30, 8'h18, 8'h7A, 8'h10, 8'h38, 8'h5A, 8'h42, 8'h4A, 8'h52
    };
    localparam t_windows DEFAULT_WINDOWS = '{
        leader_min: 16'd13000, leader_max: 16'd14000,
        repeat_min: 16'd11000, repeat_max: 16'd12000,
        zero_min: 16'd1000, zero_max: 16'd1500,
        one_min: 16'd2000, one_max: 16'd2500
    };

    localparam t_row DIRECTED [23] = '{
        '{ROW_AT, 32'hFFFF_FFFF, '0, 1'b1, NO_KEY},          // first edge: time only
        '{ROW_GAP, 32'(GAP_REPEAT), '0, 1'b1, NO_KEY},       // wraps; no key known yet
        '{ROW_GAP, 32'(GAP_ONE), '0, 1'b1, NO_KEY},          // bit outside a frame
        '{ROW_FRAME, 32'h68, '0, 1'b1, '{1'b1, 4'd0, 1'b0}},
        '{ROW_GAP, 32'(GAP_REPEAT), '0, 1'b1, '{1'b1, 4'd0, 1'b1}},
        '{ROW_FRAME, 32'h52, '0, 1'b1, '{1'b1, 4'd9, 1'b0}},
        '{ROW_FRAME, 32'hFF, '0, 1'b1, NO_KEY},              // byte not in table
        '{ROW_GAP, 32'(GAP_REPEAT), '0, 1'b1, '{1'b1, 4'd9, 1'b1}},
        '{ROW_GAP, 32'(GAP_LEADER), '0, 1'b0, NO_KEY},
        '{ROW_GAP, 32'(GAP_ONE), '0, 1'b0, NO_KEY},
        '{ROW_GAP, 32'(GAP_ZERO), '0, 1'b0, NO_KEY},
        '{ROW_FRAME, 32'h7A, '0, 1'b1, '{1'b1, 4'd3, 1'b0}}, // leader restarts frame
        '{ROW_GAP, 32'(GAP_LEADER), '0, 1'b0, NO_KEY},
        '{ROW_GAP, 32'(GAP_ZERO), '0, 1'b0, NO_KEY},
        '{ROW_GAP, 32'(GAP_REPEAT), '0, 1'b1, '{1'b1, 4'd3, 1'b1}}, // closes frame
        '{ROW_GAP, 32'(GAP_ONE), '0, 1'b1, NO_KEY},
        '{ROW_FRAME, 32'h30, 32'h00F0_000F, 1'b0, NO_KEY},   // holes keep old bits
        '{ROW_AT, 32'h0000_0000, '0, 1'b0, NO_KEY},
        '{ROW_CFG, {13'd0, REG_ZERO_MIN, 16'd900}, '0, 1'b0, NO_KEY},
        '{ROW_CFG, {13'd0, REG_ZERO_MAX, 16'd1600}, '0, 1'b0, NO_KEY},
        '{ROW_CFG, {13'd0, REG_ONE_MIN, 16'd1400}, '0, 1'b0, NO_KEY},
        '{ROW_FRAME, 32'h18, '0, 1'b1, '{1'b1, 4'd2, 1'b0}}, // ones in both windows
        '{ROW_GAP, 32'(GAP_REPEAT), '0, 1'b1, '{1'b1, 4'd2, 1'b1}}
    };

    localparam t_window_set PLAN [NUM_PHASES] = '{
        WIN_DEFAULT, WIN_OVERLAP, WIN_SCALED,
        WIN_EXTREME, WIN_DEAD, WIN_SCALED,
        WIN_NOISE, WIN_SCALED, WIN_DEFAULT
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [TIME_W-1:0]   i_edge_time = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [KEY_W-1:0]    o_key_digit;
    logic                o_is_repeat;

    // decoder model state
    t_windows            win;
    logic [TIME_W-1:0]   last_edge;
    logic                edge_seen;
    logic                frame_live;
    logic [POS_W-1:0]    bit_slot;
    logic [31:0]         frame_word;
    logic [KEY_W-1:0]    held_key;
    logic                held_valid;

    t_key_result         pending_keys [$];
    logic [TIME_W-1:0]   edge_clock = '0;
    int                  send_idle_pct = 20;
    int                  recv_idle_pct = 80;
    int                  edges_sent = 0;
    int                  keys_seen = 0;
    int                  repeats_seen = 0;
    int                  mismatches = 0;
    int unsigned         cycles = 0;

    ir_pulse_distance_key_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_edge_time (i_edge_time),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key_digit (o_key_digit),
        .o_is_repeat (o_is_repeat)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("ir_pulse_distance_key_decoder test failed");
            $finish;
        end
    end

    function automatic logic in_span(input logic [31:0] v, input logic [15:0] lo,
                                     input logic [15:0] hi);
        return (v > {16'd0, lo}) && (v < {16'd0, hi});
    endfunction

    // Advance the decoder model by one edge and return the key it emits.
    function automatic t_key_result predict_key(input logic [TIME_W-1:0] t);
        logic [31:0] span;
        logic [7:0]  code;
        t_key_result r;
        r = NO_KEY;
        if (!edge_seen) begin
            last_edge = t;
            edge_seen = 1'b1;
            return r;
        end
        span = t - last_edge;
        last_edge = t;
        if (in_span(span, win.leader_min, win.leader_max)) begin
            frame_live = 1'b1;
            bit_slot = '0;
            return r;
        end
        if (in_span(span, win.repeat_min, win.repeat_max)) begin
            frame_live = 1'b0;
            bit_slot = '0;
            if (held_valid)
                r = '{1'b1, held_key, 1'b1};
            return r;
        end
        if (!frame_live)
            return r;
        if (in_span(span, win.zero_min, win.zero_max))
            frame_word[bit_slot] = 1'b0;
        if (in_span(span, win.one_min, win.one_max))
            frame_word[bit_slot] = 1'b1;
        if (bit_slot != LAST_BIT_POS) begin
            bit_slot = bit_slot + 1'b1;
            return r;
        end
        frame_live = 1'b0;
        bit_slot = '0;
        // first frame bit of the key byte is its MSB
        for (int p = KEY_BYTE_FIRST; p <= KEY_BYTE_LAST; p++)
            code[int'(KEY_BYTE_LAST) - p] = frame_word[p];
        for (int k = 0; k < NUM_CODES; k++) begin
            if (code == KEY_CODES[k]) begin
                held_key = KEY_W'(k);
                held_valid = 1'b1;
                r = '{1'b1, KEY_W'(k), 1'b0};
            end
        end
        return r;
    endfunction

    // Pick an interval of the given kind under the current windows.
    function automatic logic [31:0] gap_for(input t_gap_kind g);
        int lo;
        int hi;
        int quiet;
        case (g)
            GAP_LEADER: begin
                lo = win.leader_min;
                hi = win.leader_max;
            end
            GAP_REPEAT: begin
                lo = win.repeat_min;
                hi = win.repeat_max;
            end
            GAP_ZERO: begin
                lo = win.zero_min;
                hi = win.zero_max;
                // stay out of the one window so the bit reads as zero
                if (win.one_min >= lo && win.one_min < hi)
                    hi = win.one_min + 1;
            end
            GAP_ONE: begin
                lo = win.one_min;
                hi = win.one_max;
                if ($urandom_range(1) == 1) begin
                    // aim where both bit windows meet, if they do
                    if (win.zero_min > lo)
                        lo = win.zero_min;
                    if (win.zero_max < hi)
                        hi = win.zero_max;
                    if (hi <= lo + 1) begin
                        lo = win.one_min;
                        hi = win.one_max;
                    end
                end
            end
            default: begin
                // at or below every lower bound hits no window
                quiet = win.leader_min;
                if (win.repeat_min < quiet)
                    quiet = win.repeat_min;
                if (win.zero_min < quiet)
                    quiet = win.zero_min;
                if (win.one_min < quiet)
                    quiet = win.one_min;
                return $urandom_range(quiet, 0);
            end
        endcase
        if (hi > lo + 1)
            return $urandom_range(hi - 1, lo + 1);
        return $urandom_range(65535, 0);
    endfunction

    task automatic send_edge(input logic [TIME_W-1:0] t, input logic typed,
                             input t_key_result typed_res);
        t_key_result want;
        want = predict_key(t);
        if (typed)
            want = typed_res;
        if (want.hit)
            pending_keys.push_back(want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_edge_time <= t;
        do @(posedge i_clk); while (!o_in_ready);
        edges_sent++;
    endtask

    task automatic send_gap(input t_gap_kind g, input logic typed,
                            input t_key_result typed_res);
        edge_clock = edge_clock + gap_for(g);
        send_edge(edge_clock, typed, typed_res);
    endtask

    // Leader, then nbits bit intervals; hole positions get an interval in no window.
    task automatic send_frame(input logic [7:0] code, input logic [31:0] holes,
                              input int nbits, input logic typed,
                              input t_key_result typed_res);
        logic [31:0] word;
        t_gap_kind   g;
        word = $urandom;
        for (int p = KEY_BYTE_FIRST; p <= KEY_BYTE_LAST; p++)
            word[p] = code[int'(KEY_BYTE_LAST) - p];
        send_gap(GAP_LEADER, 1'b0, NO_KEY);
        for (int i = 0; i < nbits; i++) begin
            g = holes[i] ? GAP_NONE : (word[i] ? GAP_ONE : GAP_ZERO);
            send_gap(g, typed && i == 31, typed_res);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input t_reg_idx r, input logic [WIN_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // struct fields sit in register order from the top
        win[(7 - int'(r)) * WIN_W +: WIN_W] = v;
    endtask

    always @(posedge i_clk) begin : take_keys
        t_key_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_keys.size() == 0) begin
                    $error("unexpected key transaction: key_digit %0d is_repeat %0b",
                           o_key_digit, o_is_repeat);
                    mismatches++;
                end else begin
                    want = pending_keys.pop_front();
                    if (o_key_digit !== want.digit) begin
                        $error("key_digit: expected %0d, got %0d", want.digit, o_key_digit);
                        mismatches++;
                    end
                    if (o_is_repeat !== want.rep) begin
                        $error("is_repeat: expected %0b, got %0b", want.rep, o_is_repeat);
                        mismatches++;
                    end
                    keys_seen++;
                    if (want.rep)
                        repeats_seen++;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        t_row       row;
        t_windows   w;
        int         start;
        int         pick;
        int         nbits;
        logic [7:0] code;
        logic [31:0] holes;
        int         zl, zh, ol, oh, rl, rh, ll, lh;

        win = DEFAULT_WINDOWS;
        last_edge = '0;
        edge_seen = 1'b0;
        frame_live = 1'b0;
        bit_slot = '0;
        frame_word = '0;
        held_key = '0;
        held_valid = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[n]) begin
            row = DIRECTED[n];
            case (row.kind)
                ROW_AT: begin
                    edge_clock = row.arg;
                    send_edge(edge_clock, row.typed, row.res);
                end
                ROW_GAP:   send_gap(t_gap_kind'(row.arg[2:0]), row.typed, row.res);
                ROW_FRAME: send_frame(row.arg[7:0], row.holes, 32, row.typed, row.res);
                default: begin
                    wait_idle();
                    write_window(t_reg_idx'(row.arg[18:16]), row.arg[15:0]);
                end
            endcase
        end
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 80;
                end
                1: begin
                    send_idle_pct = 80;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case (PLAN[phase])
                WIN_DEFAULT: w = DEFAULT_WINDOWS;
                WIN_OVERLAP: w = '{
                    leader_min: 16'd12000, leader_max: 16'd14000,
                    repeat_min: 16'd11000, repeat_max: 16'd12500,
                    zero_min: 16'd900, zero_max: 16'd1600,
                    one_min: 16'd1400, one_max: 16'd2500};
                WIN_EXTREME: w = '{
                    leader_min: 16'd50000, leader_max: 16'd65535,
                    repeat_min: 16'd30000, repeat_max: 16'd40000,
                    zero_min: 16'd0, zero_max: 16'd4,
                    one_min: 16'd2, one_max: 16'd9};
                WIN_DEAD: w = '{
                    leader_min: 16'd14000, leader_max: 16'd13000,
                    repeat_min: 16'd11000, repeat_max: 16'd12000,
                    zero_min: 16'd1200, zero_max: 16'd1200,
                    one_min: 16'd2000, one_max: 16'd2500};
                WIN_NOISE: w = {$urandom, $urandom, $urandom, $urandom};
                default: begin
                    // stacked windows at random scale; bit windows, and repeat and leader, may overlap
                    zl = $urandom_range(2000, 0);
                    zh = zl + $urandom_range(800, 2);
                    ol = zh + $urandom_range(500, 0) - 100;
                    if (ol < 0)
                        ol = 0;
                    oh = ol + $urandom_range(800, 2);
                    rl = oh + $urandom_range(20000, 100);
                    rh = rl + $urandom_range(3000, 2);
                    ll = rh + $urandom_range(10000, 0) - 50;
                    lh = ll + $urandom_range(5000, 2);
                    w = '{leader_min: ll[15:0], leader_max: lh[15:0],
                          repeat_min: rl[15:0], repeat_max: rh[15:0],
                          zero_min: zl[15:0], zero_max: zh[15:0],
                          one_min: ol[15:0], one_max: oh[15:0]};
                end
            endcase
            for (int r = 0; r < 8; r++)
                write_window(t_reg_idx'(r), w[(7 - r) * WIN_W +: WIN_W]);

            start = edges_sent;
            while (edges_sent - start < EDGES_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    code = ($urandom_range(9) < 8) ? KEY_CODES[$urandom_range(NUM_CODES - 1)]
                                                   : 8'($urandom);
                    holes = ($urandom_range(9) == 0) ? ($urandom & $urandom & $urandom) : '0;
                    nbits = ($urandom_range(9) == 0) ? $urandom_range(31, 1) : 32;
                    send_frame(code, holes, nbits, 1'b0, NO_KEY);
                end else if (pick < 75) begin
                    send_gap(GAP_REPEAT, 1'b0, NO_KEY);
                end else if (pick < 88) begin
                    send_gap(t_gap_kind'($urandom_range(4)), 1'b0, NO_KEY);
                end else begin
                    edge_clock = $urandom;
                    send_edge(edge_clock, 1'b0, NO_KEY);
                end
            end
            wait_idle();
        end

        $display("Sent %0d edge transactions under %0d window settings.",
                 edges_sent, NUM_PHASES + 1);
        $display("Checked %0d decoded keys, %0d of them from repeat codes.",
                 keys_seen, repeats_seen);
        if (mismatches == 0) begin
            $display("ir_pulse_distance_key_decoder test passed");
        end else begin
            $display("ir_pulse_distance_key_decoder test failed");
        end
        $finish;
    end

endmodule
